// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the sigmoid evaluator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== hdl/smem_pkg.sv =====
// ----------------------------------------------------------------------------
// smem_pkg
// Types, constants and the logistic table generator of the sigmoid evaluator.
// ----------------------------------------------------------------------------
package smem_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int SLOPE_W          = 13;
  localparam int DIFF_W           = SAMPLE_W + 1;
  localparam int ARG_W            = DIFF_W + SLOPE_W;
  localparam int GRADE_W          = 15;
  localparam int MEMB_W           = 16;
  // The argument a*(x-c) carries 16 fraction bits, so 8.0 sits at bit 19.
  localparam int FRAC_BITS        = 19;
  localparam int ONE_Q14          = 16384;
  localparam int CFG_ADDR_W       = 5;
  localparam int CFG_DATA_W       = 32;
  localparam int DEF_TABLE_POINTS = 64;
  localparam int NUM_STAGES       = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SLOPE_W-1:0]  slope_t;
  typedef logic [GRADE_W-1:0]         grade_t;
  typedef logic signed [MEMB_W-1:0]   membership_t;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_DIFF   = 2'd1,
    MODE_PROD   = 2'd2
  } shape_mode_t;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_SLOPE_ONE  = 3'd1,
    REG_CENTRE_ONE = 3'd2,
    REG_SLOPE_TWO  = 3'd3,
    REG_CENTRE_TWO = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] shape_mode;
    slope_t     slope_one;
    sample_t    centre_one;
    slope_t     slope_two;
    sample_t    centre_two;
  } smem_cfg_t;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } smem_adv_t;

  // Unsigned quotient by restoring shift and subtract. Only evaluated at
  // elaboration while the constant table is built.
  function automatic logic [63:0] const_quot(input logic [63:0] num,
                                             input logic [63:0] dvs);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Logistic value at 8k/points in unsigned Q1.14. exp(u) is summed as a
  // truncated Taylor series in unsigned Q.32; a term stays zero once it
  // reaches zero. Only evaluated at elaboration to build the constant table.
  function automatic grade_t rom_entry(input int k, input int points);
    logic [63:0] one_v;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    one_v = 64'd1 << 32;
    term  = one_v;
    sum   = one_v;
    for (int n = 1; n < 100; n++) begin
      term = const_quot(term * 64'(8 * k), 64'(points) * 64'(n));
      sum  = sum + term;
    end
    den = sum + one_v;
    return GRADE_W'(const_quot(sum * 64'(ONE_Q14) + (den >> 1), den));
  endfunction

endpackage

// ===== hdl/smem_in_if.sv =====
// ----------------------------------------------------------------------------
// smem_in_if
// Sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface smem_in_if import smem_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== hdl/smem_out_if.sv =====
// ----------------------------------------------------------------------------
// smem_out_if
// Membership grade channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface smem_out_if import smem_pkg::*; ();
  logic        valid;
  logic        ready;
  membership_t membership;

  modport source (output valid, output membership, input ready);
  modport sink (input valid, input membership, output ready);
endinterface

// ===== hdl/smem_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// smem_cfg_regs
// APB-style register file holding the mode, slopes and centres.
// ----------------------------------------------------------------------------
module smem_cfg_regs import smem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output smem_cfg_t             cfg
);

  smem_cfg_t cfg_r;
  smem_cfg_t cfg_nxt;
  reg_idx_t  reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SHAPE_MODE: cfg_nxt.shape_mode = pwdata[1:0];
        REG_SLOPE_ONE:  cfg_nxt.slope_one  = slope_t'(pwdata[SLOPE_W-1:0]);
        REG_CENTRE_ONE: cfg_nxt.centre_one = sample_t'(pwdata[SAMPLE_W-1:0]);
        REG_SLOPE_TWO:  cfg_nxt.slope_two  = slope_t'(pwdata[SLOPE_W-1:0]);
        REG_CENTRE_TWO: cfg_nxt.centre_two = sample_t'(pwdata[SAMPLE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shape_mode <= MODE_SINGLE;
      cfg_r.slope_one  <= slope_t'(256);
      cfg_r.centre_one <= '0;
      cfg_r.slope_two  <= slope_t'(256);
      cfg_r.centre_two <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHAPE_MODE: prdata = CFG_DATA_W'(cfg_r.shape_mode);
      REG_SLOPE_ONE:  prdata = CFG_DATA_W'(unsigned'(cfg_r.slope_one));
      REG_CENTRE_ONE: prdata = CFG_DATA_W'(unsigned'(cfg_r.centre_one));
      REG_SLOPE_TWO:  prdata = CFG_DATA_W'(unsigned'(cfg_r.slope_two));
      REG_CENTRE_TWO: prdata = CFG_DATA_W'(unsigned'(cfg_r.centre_two));
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/smem_sigmoid.sv =====
// ----------------------------------------------------------------------------
// smem_sigmoid
// Four-stage logistic evaluator: difference, slope product, table lookup,
// interpolation with saturation and mirroring.
// ----------------------------------------------------------------------------
module smem_sigmoid import smem_pkg::*; #(
  parameter int TABLE_POINTS = DEF_TABLE_POINTS
) (
  input  logic      clk,
  input  smem_adv_t adv,
  input  sample_t   sample,
  input  slope_t    slope,
  input  sample_t   centre,
  output grade_t    grade
);

  localparam int IDX_W = $clog2(TABLE_POINTS + 1);
  localparam int SCL_W = FRAC_BITS + IDX_W;
  localparam int MUL_W = GRADE_W + FRAC_BITS + 1;
  localparam logic signed [ARG_W-1:0] SAT_POS = ARG_W'(1) <<< FRAC_BITS;
  localparam logic signed [ARG_W-1:0] SAT_NEG = -SAT_POS;
  localparam logic [MUL_W-1:0] ROUND_HALF = MUL_W'(1) << (FRAC_BITS - 1);
  localparam grade_t GRADE_ONE = GRADE_W'(ONE_Q14);

  grade_t rom_c [TABLE_POINTS+1];

  for (genvar k = 0; k <= TABLE_POINTS; k++) begin : g_rom
    localparam grade_t ENTRY = rom_entry(k, TABLE_POINTS);
    assign rom_c[k] = ENTRY;
  end

  // Stage 1: x - c.
  logic signed [DIFF_W-1:0] diff_r;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      diff_r <= DIFF_W'(sample) - DIFF_W'(centre);
    end
  end

  // Stage 2: exact argument a*(x-c).
  logic signed [ARG_W-1:0] arg_r;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      arg_r <= ARG_W'(slope) * ARG_W'(diff_r);
    end
  end

  // Stage 3: saturation flags, table index, lookup and remainder.
  logic                    sat_hi;
  logic                    sat_lo;
  logic                    neg;
  logic [ARG_W-1:0]        abs_arg;
  logic [FRAC_BITS-1:0]    mag;
  logic [SCL_W-1:0]        scaled;
  logic [IDX_W-1:0]        idx;
  grade_t                  lo;
  grade_t                  hi;
  grade_t                  step;

  assign sat_hi  = arg_r >= SAT_POS;
  assign sat_lo  = arg_r <= SAT_NEG;
  assign neg     = arg_r[ARG_W-1];
  assign abs_arg = neg ? ARG_W'(-arg_r) : ARG_W'(arg_r);
  assign mag     = abs_arg[FRAC_BITS-1:0];
  assign scaled  = SCL_W'(mag) * SCL_W'(TABLE_POINTS);
  assign idx     = scaled[SCL_W-1:FRAC_BITS];
  assign lo      = rom_c[idx];
  assign hi      = rom_c[IDX_W'(idx + 1'b1)];
  assign step    = (hi >= lo) ? GRADE_W'(hi - lo) : '0;

  logic                 sat_hi_r;
  logic                 sat_lo_r;
  logic                 neg_r;
  grade_t               lo_r;
  grade_t               step_r;
  logic [FRAC_BITS-1:0] rem_r;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      sat_hi_r <= sat_hi;
      sat_lo_r <= sat_lo;
      neg_r    <= neg;
      lo_r     <= lo;
      step_r   <= step;
      rem_r    <= scaled[FRAC_BITS-1:0];
    end
  end

  // Stage 4: rounded interpolation, then saturation and s(-u) = 1 - s(u).
  logic [MUL_W-1:0] prod;
  logic [MUL_W-1:0] rnd;
  grade_t           interp;
  grade_t           grade_nxt;
  grade_t           grade_r;

  assign prod   = MUL_W'(step_r) * MUL_W'(rem_r);
  assign rnd    = prod + ROUND_HALF;
  assign interp = GRADE_W'(lo_r + rnd[FRAC_BITS +: GRADE_W]);

  always_comb begin
    if (sat_hi_r) begin
      grade_nxt = GRADE_ONE;
    end else if (sat_lo_r) begin
      grade_nxt = '0;
    end else if (neg_r) begin
      grade_nxt = GRADE_W'(GRADE_ONE - interp);
    end else begin
      grade_nxt = interp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      grade_r <= grade_nxt;
    end
  end

  assign grade = grade_r;

endmodule

// ===== hdl/smem_combine.sv =====
// ----------------------------------------------------------------------------
// smem_combine
// Output stage: selects, subtracts or multiplies the two grades.
// ----------------------------------------------------------------------------
module smem_combine import smem_pkg::*; (
  input  logic        clk,
  input  smem_adv_t   adv,
  input  logic [1:0]  shape_mode,
  input  grade_t      grade_one,
  input  grade_t      grade_two,
  output membership_t membership
);

  localparam int PROD_W = 2 * GRADE_W;
  localparam logic [PROD_W-1:0] HALF_Q14 = PROD_W'(ONE_Q14 / 2);

  membership_t       diff;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rnd;
  membership_t       memb_nxt;
  membership_t       memb_r;

  assign diff = $signed({1'b0, grade_one}) - $signed({1'b0, grade_two});
  assign prod = PROD_W'(grade_one) * PROD_W'(grade_two);
  assign rnd  = prod + HALF_Q14;

  // Unused mode code behaves as the single sigmoid.
  always_comb begin
    case (shape_mode)
      MODE_DIFF: memb_nxt = diff;
      MODE_PROD: memb_nxt = $signed(rnd[14 +: MEMB_W]);
      default:   memb_nxt = $signed({1'b0, grade_one});
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      memb_r <= memb_nxt;
    end
  end

  assign membership = memb_r;

endmodule

// ===== hdl/sigmoid_membership_eval.sv =====
// ----------------------------------------------------------------------------
// sigmoid_membership_eval
// Fuzzy sigmoid membership evaluator: single, difference or product of two
// logistic curves of a Q7.8 sample, giving a signed Q1.14 membership grade.
// Usage: samples arrive on in_ch (valid/ready) and grades leave on out_ch.
// Every sample gives exactly one grade, in order. The APB-style port sets
// mode, slopes and centres; write it only while no transaction is in flight.
// Throughput is one sample per cycle while the receiver keeps ready high.
// Each sample walks through five register stages (difference, slope
// product, table lookup, interpolation, combine). A stalled receiver
// holds the output register and stages fill in behind it; input ready
// drops only once every stage is full.
// Reset clears all stage valid bits and loads the register reset values.
// The logistic table is constant logic, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module sigmoid_membership_eval import smem_pkg::*; #(
  parameter int TABLE_POINTS = DEF_TABLE_POINTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  smem_in_if.sink               in_ch,
  smem_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  smem_cfg_t cfg;

  // Configuration registers. They feed every stage directly, so the user must
  // only change them while the pipeline is empty; no logic here enforces it.
  smem_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // One valid bit per stage; the last one is the output register's.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  smem_adv_t             adv;

  // A stage loads when it is empty or when the stage after it loads, so
  // bubbles collapse and a stall only backs up as far as full stages go.
  assign adv.s5 = !vld_r[4] || out_ch.ready;
  assign adv.s4 = !vld_r[3] || adv.s5;
  assign adv.s3 = !vld_r[2] || adv.s4;
  assign adv.s2 = !vld_r[1] || adv.s3;
  assign adv.s1 = !vld_r[0] || adv.s2;

  assign in_ch.ready = adv.s1;

  always_comb begin
    vld_nxt = vld_r;
    if (adv.s1) vld_nxt[0] = in_ch.valid;
    if (adv.s2) vld_nxt[1] = vld_r[0];
    if (adv.s3) vld_nxt[2] = vld_r[1];
    if (adv.s4) vld_nxt[3] = vld_r[2];
    if (adv.s5) vld_nxt[4] = vld_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Two logistic evaluators run side by side on the same sample. The
  // second one is computed in every mode and simply ignored in single mode.
  grade_t grade_one;
  grade_t grade_two;

  smem_sigmoid #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_sigmoid_one (
    .clk    (clk),
    .adv    (adv),
    .sample (in_ch.sample),
    .slope  (cfg.slope_one),
    .centre (cfg.centre_one),
    .grade  (grade_one)
  );

  smem_sigmoid #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_sigmoid_two (
    .clk    (clk),
    .adv    (adv),
    .sample (in_ch.sample),
    .slope  (cfg.slope_two),
    .centre (cfg.centre_two),
    .grade  (grade_two)
  );

  // Final stage: mode selection, doubling as the output register.
  smem_combine u_combine (
    .clk        (clk),
    .adv        (adv),
    .shape_mode (cfg.shape_mode),
    .grade_one  (grade_one),
    .grade_two  (grade_two),
    .membership (out_ch.membership)
  );

  assign out_ch.valid = vld_r[4];

endmodule

// ===== hdl/smem_checker.sv =====
// ----------------------------------------------------------------------------
// smem_checker
// Port-level checks of the sigmoid evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smem_checker import smem_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input membership_t membership
);

  localparam membership_t MEMB_MAX = MEMB_W'(ONE_Q14);
  localparam membership_t MEMB_MIN = -MEMB_MAX;

  // Reset empties the pipeline.
  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid)

  // An output register that can move means every stage can move, so the
  // sample side is never held off then.
  `ASSERT_ALWAYS(a_ready_follows_out, clk, (!out_valid || out_ready) |-> in_ready)

  // Grades stay within -1.0 .. 1.0.
  `ASSERT_CLK(a_grade_range, clk, rst_n,
    out_valid |-> (membership >= MEMB_MIN && membership <= MEMB_MAX))

  // A stalled result stays and holds its value.
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(membership)))

  // Ready on the sample side is never unknown when a sample is accepted.
  `ASSERT_CLK(a_accept_known, clk, rst_n, (in_valid && in_ready) |-> !$isunknown(in_ready))

endmodule

bind sigmoid_membership_eval smem_checker u_smem_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .membership (out_ch.membership)
);

// ===== tb/sv/smem_grade_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smem_grade_checker
// Watches the sample channel, the grade channel and the register port of the
// sigmoid evaluator, predicts each membership grade and compares it in order.
// ----------------------------------------------------------------------------
module smem_grade_checker import smem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  smem_in_if                    in_mon,
  smem_out_if                   out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    pending
);

  localparam int     CURVE_POINTS = DEF_TABLE_POINTS;
  localparam longint ARG_EIGHT    = longint'(1) << FRAC_BITS;

  // Own copy of the register file, updated from observed writes.
  logic [1:0] mode_q;
  slope_t     slope1_q;
  sample_t    centre1_q;
  slope_t     slope2_q;
  sample_t    centre2_q;

  int          curve [0:CURVE_POINTS];
  membership_t predicted_grades [$];

  // Logistic value at 8k/points in Q1.14, from a Taylor series of exp(u)
  // in unsigned Q.32 that stops at the first zero term.
  function automatic int curve_value(input int k);
    longint unsigned unit;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned den;
    longint unsigned numer;
    longint unsigned denom;
    int              n;
    unit = 64'd1 << 32;
    term = unit;
    acc  = unit;
    n    = 1;
    while (n < 100 && term != 0) begin
      numer = 64'(8 * k);
      denom = 64'(CURVE_POINTS * n);
      term  = term * numer / denom;
      acc   = acc + term;
      n++;
    end
    den = acc + unit;
    return int'((acc * 64'(ONE_Q14) + den / 2) / den);
  endfunction

  // One sigmoid: exact argument, saturation at +-8, interpolated table,
  // and the mirror 1 - s(|t|) for negative arguments.
  function automatic int logistic_grade(input slope_t a, input sample_t c,
                                        input sample_t x);
    longint arg;
    longint mag;
    longint scaled;
    longint frac;
    longint lo;
    longint hi;
    longint rise;
    longint s;
    int     idx;
    arg = longint'(a) * (longint'(x) - longint'(c));
    if (arg >= ARG_EIGHT) return ONE_Q14;
    if (arg <= -ARG_EIGHT) return 0;
    mag    = (arg < 0) ? -arg : arg;
    scaled = mag * CURVE_POINTS;
    idx    = int'(scaled >>> FRAC_BITS);
    frac   = scaled & (ARG_EIGHT - 1);
    if (idx >= CURVE_POINTS) begin
      idx  = CURVE_POINTS - 1;
      frac = ARG_EIGHT;
    end
    lo   = curve[idx];
    hi   = curve[idx + 1];
    rise = (hi >= lo) ? hi - lo : 0;
    s    = lo + (rise * frac + ARG_EIGHT / 2) / ARG_EIGHT;
    return (arg < 0) ? int'(ONE_Q14 - s) : int'(s);
  endfunction

  function automatic membership_t predict_grade(input sample_t x);
    longint g1;
    longint g2;
    longint r;
    g1 = logistic_grade(slope1_q, centre1_q, x);
    r  = g1;
    if (mode_q == MODE_DIFF || mode_q == MODE_PROD) begin
      g2 = logistic_grade(slope2_q, centre2_q, x);
      if (mode_q == MODE_DIFF) begin
        r = g1 - g2;
      end else begin
        r = (g1 * g2 + ONE_Q14 / 2) >>> 14;
      end
    end
    if (r > ONE_Q14) r = ONE_Q14;
    if (r < -ONE_Q14) r = -ONE_Q14;
    return membership_t'(r);
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
    for (int k = 0; k <= CURVE_POINTS; k++) begin
      curve[k] = curve_value(k);
    end
  end

  always @(posedge clk) begin
    membership_t want;
    if (!rst_n) begin
      mode_q    = MODE_SINGLE;
      slope1_q  = slope_t'(256);
      centre1_q = '0;
      slope2_q  = slope_t'(256);
      centre2_q = '0;
      predicted_grades.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_SHAPE_MODE: mode_q    = pwdata[1:0];
          REG_SLOPE_ONE:  slope1_q  = pwdata[SLOPE_W-1:0];
          REG_CENTRE_ONE: centre1_q = pwdata[SAMPLE_W-1:0];
          REG_SLOPE_TWO:  slope2_q  = pwdata[SLOPE_W-1:0];
          REG_CENTRE_TWO: centre2_q = pwdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predicted_grades.push_back(predict_grade(in_mon.sample));
        pending++;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_grades.size() == 0) begin
          $display("%0t: unexpected grade transaction, expected none, actual %0d",
                   $time, out_mon.membership);
          mismatches++;
        end else begin
          want = predicted_grades.pop_front();
          pending--;
          if (out_mon.membership !== want) begin
            $display("%0t: membership mismatch, expected %0d, actual %0d",
                     $time, want, out_mon.membership);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/sigmoid_membership_eval_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigmoid_membership_eval_tb
// Drives samples and register writes into the sigmoid evaluator under random
// handshake pressure; a side checker predicts and compares every grade.
// ----------------------------------------------------------------------------
module sigmoid_membership_eval_tb import smem_pkg::*; ();

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 2 * NUM_STAGES;
  localparam int         RANDOM_PHASES = 10;
  localparam int         PHASE_ITEMS   = 153;
  // The mode field is two bits wide; its fourth code is not in the package
  // enum and must act like the single sigmoid.
  localparam logic [1:0] MODE_SPARE    = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending_grades;
  int                    cycle_count;
  int                    grades_taken;
  bit                    tx_burst;
  bit                    rx_burst;

  smem_in_if  in_ch ();
  smem_out_if out_ch ();

  sigmoid_membership_eval dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  smem_grade_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (fail_count),
    .pending    (pending_grades)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog, set above the slowest legal run: every sample can wait for a
  // random gap at each side plus the five pipeline stages.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One register write: a setup phase, then the access phase, which ends at
  // the rising edge where pready is seen high.
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_shape(input logic [CFG_DATA_W-1:0] mode_w,
                               input logic [CFG_DATA_W-1:0] slope1_w,
                               input logic [CFG_DATA_W-1:0] centre1_w,
                               input logic [CFG_DATA_W-1:0] slope2_w,
                               input logic [CFG_DATA_W-1:0] centre2_w);
    cfg_write(REG_SHAPE_MODE, mode_w);
    cfg_write(REG_SLOPE_ONE, slope1_w);
    cfg_write(REG_CENTRE_ONE, centre1_w);
    cfg_write(REG_SLOPE_TWO, slope2_w);
    cfg_write(REG_CENTRE_TWO, centre2_w);
  endtask

  // Offers one sample after a random gap and returns at the rising edge that
  // accepted it. The next call starts at the following falling edge, so valid
  // only drops when a gap is actually drawn.
  task automatic send_sample(input sample_t value);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering and waits until every predicted grade has come back, so
  // that the registers may be rewritten safely.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_grades == 0);
  endtask

  function automatic slope_t pick_slope();
    case ($urandom_range(0, 7))
      0: return slope_t'(-4096);
      1: return slope_t'(4095);
      2: return slope_t'($urandom);
      default: return slope_t'(int'($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  function automatic sample_t pick_centre();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return sample_t'($urandom);
      default: return sample_t'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // Most samples land inside the window where |a*(x-c)| < 8, so that the
  // table interpolation and the mirror of negative arguments get exercised;
  // the rest are raw 16-bit patterns and the two extremes.
  function automatic sample_t pick_sample(input bit two_curves,
                                          input slope_t a1, input sample_t c1,
                                          input slope_t a2, input sample_t c2);
    slope_t  a;
    sample_t c;
    int      mag;
    int      span;
    int      v;
    if (two_curves && $urandom_range(0, 1) == 1) begin
      a = a2;
      c = c2;
    end else begin
      a = a1;
      c = c1;
    end
    case ($urandom_range(0, 9))
      0, 1: return sample_t'($urandom);
      2: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      default: begin
        mag  = (a < 0) ? -int'(a) : int'(a);
        span = (mag == 0) ? 32767 : (1 << FRAC_BITS) / mag + 2;
        if (span > 32767) span = 32767;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return sample_t'(v);
      end
    endcase
  endfunction

  // Result side. Each grade waits a random number of cycles unless a burst
  // stretch is running. Twice in the run the receiver goes quiet for a long
  // stretch while the sender is still offering, which fills every stage and
  // forces input ready low.
  initial begin
    int wait_cycles;
    int next_hold;
    out_ch.ready = 1'b0;
    grades_taken = 0;
    rx_burst     = 1'b0;
    next_hold    = 400;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (grades_taken >= next_hold && in_ch.valid) begin
        out_ch.ready <= 1'b0;
        next_hold = next_hold + 600;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      wait_cycles = rx_burst ? 0 : $urandom_range(0, 19);
      if (wait_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      grades_taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [1:0] mode;
    slope_t     a1;
    slope_t     a2;
    sample_t    c1;
    sample_t    c2;
    bit         two_curves;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    tx_burst     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: a unit slope centered at zero. The
    // samples hit both field extremes, the exact saturation points at +-8.0
    // and the last interpolation interval just short of them.
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    send_sample(16'sh0800);
    send_sample(16'shF800);
    send_sample(16'sh07FF);
    send_sample(16'shF801);
    drain();

    // Difference of the two steepest opposite slopes at opposite centres.
    program_shape(MODE_DIFF, 32'(-4096), 32'(-32768), 32'(4095), 32'(32767));
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    drain();

    // Product with a flat first curve (zero slope gives exactly one half)
    // and the shallowest second slope across the full sample range.
    program_shape(MODE_PROD, 32'(0), 32'(0), 32'(1), 32'(-32768));
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
    drain();

    // Spare mode code and register writes with junk above the field width;
    // only the low bits may take effect.
    program_shape({30'h3FFF_FFFF, MODE_SPARE}, 32'hFFFF_FF00, 32'hABCD_0100,
                  32'h5A5A_E000, 32'hFFFF_8000);
    send_sample(16'sh0100);
    send_sample(16'shFF00);
    send_sample(16'sh2AAA);
    send_sample(16'shD556);
    drain();

    // Identical curves: the difference is zero and the product of two
    // halves exercises the rounding of the product.
    program_shape(MODE_DIFF, 32'(512), 32'(100), 32'(512), 32'(100));
    send_sample(16'sd100);
    send_sample(16'sd5000);
    drain();
    program_shape(MODE_PROD, 32'(256), 32'(0), 32'(256), 32'(0));
    send_sample(16'sh0000);
    send_sample(16'sh8000);
    drain();

    // Random part: the first two phases pin every register at an extreme, the
    // rest but the third draw mode, slopes and centres at random.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          mode = MODE_PROD;
          a1   = slope_t'(4095);
          c1   = 16'sh7FFF;
          a2   = slope_t'(-4096);
          c2   = 16'sh8000;
        end
        1: begin
          mode = MODE_DIFF;
          a1   = slope_t'(-4096);
          c1   = 16'sh8000;
          a2   = slope_t'(4095);
          c2   = 16'sh7FFF;
        end
        2: begin
          mode = MODE_SINGLE;
          a1   = slope_t'(4095);
          c1   = 16'sh0000;
          a2   = slope_t'(1);
          c2   = 16'sh0000;
        end
        default: begin
          mode = 2'($urandom_range(0, 3));
          a1   = pick_slope();
          c1   = pick_centre();
          a2   = pick_slope();
          c2   = pick_centre();
        end
      endcase
      program_shape(32'(mode), 32'(a1), 32'(c1), 32'(a2), 32'(c2));
      two_curves = (mode == MODE_DIFF || mode == MODE_PROD);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_sample(two_curves, a1, c1, a2, c2));
      end
      drain();
    end

    // Everything is back; keep clocking the pipeline so that any stray grade
    // shows before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/smem_pkg.sv
hdl/smem_in_if.sv
hdl/smem_out_if.sv
hdl/smem_cfg_regs.sv
hdl/smem_sigmoid.sv
hdl/smem_combine.sv
hdl/sigmoid_membership_eval.sv
hdl/smem_checker.sv
tb/sv/smem_grade_checker.sv
tb/sv/sigmoid_membership_eval_tb.sv
